[rtl/ksm_pkg.sv]
// ----------------------------------------------------------------------------
// ksm_pkg: shared types and constants for the scalar Kalman smoother
// Control word layout, step addresses, register indexes and reset values.
// ----------------------------------------------------------------------------
package ksm_pkg;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD,
    OP_DIV,
    OP_GAIN,
    OP_MUL1,
    OP_EST,
    OP_ABS_MUL2,
    OP_MUL3,
    OP_UPD,
    OP_FIRST
  } op_t;

  // sequencer branch conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT_IN,
    C_IF_FIRST,
    C_LOOP,
    C_WAIT_OUT
  } cond_t;

  typedef logic [3:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // control to the datapath
  typedef struct packed {
    op_t  op;
    logic en;
  } ctrl_t;

  // status from the datapath
  typedef struct packed {
    logic first;
    logic cnt_zero;
  } stat_t;

  // program addresses
  localparam pc_t PC_IDLE  = 4'd0;
  localparam pc_t PC_LOAD  = 4'd1;
  localparam pc_t PC_DIV   = 4'd2;
  localparam pc_t PC_GAIN  = 4'd3;
  localparam pc_t PC_MUL1  = 4'd4;
  localparam pc_t PC_EST   = 4'd5;
  localparam pc_t PC_ABS   = 4'd6;
  localparam pc_t PC_MUL3  = 4'd7;
  localparam pc_t PC_UPD   = 4'd8;
  localparam pc_t PC_FIRST = 4'd9;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MNOISE   = 2'd0;
  localparam logic [1:0] REG_PNOISE   = 2'd1;
  localparam logic [1:0] REG_INIT_ERR = 2'd2;

  localparam logic [15:0] MNOISE_RST   = 16'd2560;
  localparam logic [15:0] PNOISE_RST   = 16'd64;
  localparam logic [15:0] INIT_ERR_RST = 16'd2560;

  // 17 quotient bits: counter runs 16 down to 0
  localparam logic [4:0]  DIV_CNT_INIT = 5'd16;
  localparam logic [16:0] GAIN_ONE     = 17'h10000;
  localparam logic [15:0] ERR_MAX      = 16'hFFFF;

endpackage

[rtl/ksm_rom.sv]
// ----------------------------------------------------------------------------
// ksm_rom: control store
// One control word per program step: operation, branch condition, target.
// ----------------------------------------------------------------------------
module ksm_rom (
  input  ksm_pkg::pc_t    pc,
  output ksm_pkg::uword_t uword
);
  import ksm_pkg::*;

  always_comb begin
    unique case (pc)
      PC_IDLE:  uword = '{op: OP_ACCEPT,   cond: C_WAIT_IN,  target: PC_IDLE};
      PC_LOAD:  uword = '{op: OP_LOAD,     cond: C_IF_FIRST, target: PC_FIRST};
      PC_DIV:   uword = '{op: OP_DIV,      cond: C_LOOP,     target: PC_DIV};
      PC_GAIN:  uword = '{op: OP_GAIN,     cond: C_NEXT,     target: PC_IDLE};
      PC_MUL1:  uword = '{op: OP_MUL1,     cond: C_NEXT,     target: PC_IDLE};
      PC_EST:   uword = '{op: OP_EST,      cond: C_NEXT,     target: PC_IDLE};
      PC_ABS:   uword = '{op: OP_ABS_MUL2, cond: C_NEXT,     target: PC_IDLE};
      PC_MUL3:  uword = '{op: OP_MUL3,     cond: C_NEXT,     target: PC_IDLE};
      PC_UPD:   uword = '{op: OP_UPD,      cond: C_WAIT_OUT, target: PC_IDLE};
      PC_FIRST: uword = '{op: OP_FIRST,    cond: C_WAIT_OUT, target: PC_IDLE};
      default:  uword = '{op: OP_NOP,      cond: C_WAIT_OUT, target: PC_IDLE};
    endcase
  end

endmodule

[rtl/ksm_seq.sv]
// ----------------------------------------------------------------------------
// ksm_seq: step counter and branch logic
// Advance, hold or jump the program counter per the control word condition.
// ----------------------------------------------------------------------------
module ksm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  ksm_pkg::uword_t uword,
  input  ksm_pkg::stat_t  stat,
  input  logic            in_valid,
  input  logic            out_free,
  output ksm_pkg::pc_t    pc,
  output ksm_pkg::ctrl_t  ctrl,
  output logic            in_ready
);
  import ksm_pkg::*;

  pc_t  pc_r, pc_nxt;
  logic hold;

  always_comb begin
    hold = ((uword.cond == C_WAIT_IN) && !in_valid) ||
           ((uword.cond == C_WAIT_OUT) && !out_free);
    pc_nxt = pc_r + 4'd1;
    unique case (uword.cond)
      C_NEXT:     pc_nxt = pc_r + 4'd1;
      C_WAIT_IN:  pc_nxt = in_valid ? pc_r + 4'd1 : pc_r;
      C_IF_FIRST: pc_nxt = stat.first ? uword.target : pc_r + 4'd1;
      C_LOOP:     pc_nxt = stat.cnt_zero ? pc_r + 4'd1 : uword.target;
      C_WAIT_OUT: pc_nxt = out_free ? uword.target : pc_r;
      default:    pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign pc       = pc_r;
  assign ctrl     = '{op: uword.op, en: !hold};
  assign in_ready = (uword.cond == C_WAIT_IN);

endmodule

[rtl/ksm_datapath.sv]
// ----------------------------------------------------------------------------
// ksm_datapath: filter arithmetic
// Restoring divider, one shared signed multiplier, filter state and result.
// ----------------------------------------------------------------------------
module ksm_datapath #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ksm_pkg::ctrl_t                 ctrl,
  output ksm_pkg::stat_t                 stat,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,
  input  logic [15:0]                    mnoise,
  input  logic [15:0]                    pnoise,
  input  logic [15:0]                    init_err,
  output logic                           out_load,
  output logic signed [SAMPLE_WIDTH-1:0] out_estimate,
  output logic [15:0]                    out_error_estimate,
  output logic                           out_first_sample
);
  import ksm_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int BW = (W + 1 > 17) ? W + 1 : 17;
  localparam int PW = 18 + BW;
  localparam int SW = W + 9;

  // filter state
  logic signed [W-1:0] last_r, last_nxt;
  logic [15:0]         err_r, err_nxt;
  logic                primed_r, primed_nxt;

  // working registers
  logic signed [W-1:0]  samp_r, samp_nxt;
  logic                 rst_flag_r, rst_flag_nxt;
  logic [16:0]          den_r, den_nxt;
  logic [17:0]          rem_r, rem_nxt;
  logic [16:0]          quo_r, quo_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [15:0]          gain_r, gain_nxt;
  logic signed [W:0]    diff_r, diff_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [W-1:0]  new_r, new_nxt;
  logic [W-1:0]         dabs_r, dabs_nxt;
  logic [15:0]          e1_r, e1_nxt;
  logic signed [W-1:0]  oest_r, oest_nxt;
  logic [15:0]          oerr_r, oerr_nxt;
  logic                 ofirst_r, ofirst_nxt;

  logic [15:0]          eff_err;
  logic                 div_ge;
  logic [17:0]          rem_sub;
  logic signed [17:0]   mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [W:0]    dd, dneg;
  logic [SW-1:0]        err_sum;
  logic [15:0]          err_sat;

  always_comb begin
    eff_err = rst_flag_r ? init_err : err_r;
    div_ge  = rem_r >= {1'b0, den_r};
    rem_sub = rem_r - {1'b0, den_r};
    dd      = (W + 1)'(last_r) - (W + 1)'(new_r);
    dneg    = -dd;
    err_sum = SW'(e1_r) + SW'(prod_r[8 +: W + 8]);
    err_sat = (|err_sum[SW-1:16]) ? ERR_MAX : err_sum[15:0];

    unique case (ctrl.op)
      OP_MUL1: begin
        mul_a = signed'({2'b00, gain_r});
        mul_b = BW'(diff_r);
      end
      OP_ABS_MUL2: begin
        mul_a = signed'({1'b0, GAIN_ONE - {1'b0, gain_r}});
        mul_b = signed'(BW'(err_r));
      end
      OP_MUL3: begin
        mul_a = signed'({2'b00, pnoise});
        mul_b = signed'(BW'(dabs_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    last_nxt     = last_r;
    err_nxt      = err_r;
    primed_nxt   = primed_r;
    samp_nxt     = samp_r;
    rst_flag_nxt = rst_flag_r;
    den_nxt      = den_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    cnt_nxt      = cnt_r;
    gain_nxt     = gain_r;
    diff_nxt     = diff_r;
    prod_nxt     = prod_r;
    new_nxt      = new_r;
    dabs_nxt     = dabs_r;
    e1_nxt       = e1_r;
    oest_nxt     = oest_r;
    oerr_nxt     = oerr_r;
    ofirst_nxt   = ofirst_r;
    out_load     = 1'b0;

    if (ctrl.en) begin
      unique case (ctrl.op)
        OP_ACCEPT: begin
          samp_nxt     = in_sample;
          rst_flag_nxt = in_restart;
        end
        OP_LOAD: begin
          // apply restart, then seed the divider with E / (E + R)
          err_nxt    = eff_err;
          primed_nxt = primed_r & ~rst_flag_r;
          if (rst_flag_r) begin
            last_nxt = '0;
          end
          den_nxt = {1'b0, eff_err} + {1'b0, mnoise};
          rem_nxt = {2'b00, eff_err};
          quo_nxt = '0;
          cnt_nxt = DIV_CNT_INIT;
        end
        OP_DIV: begin
          rem_nxt = div_ge ? {rem_sub[16:0], 1'b0} : {rem_r[16:0], 1'b0};
          quo_nxt = {quo_r[15:0], div_ge};
          cnt_nxt = cnt_r - 5'd1;
        end
        OP_GAIN: begin
          if (den_r == '0) begin
            gain_nxt = '0;
          end else if (quo_r[16]) begin
            gain_nxt = 16'hFFFF;
          end else begin
            gain_nxt = quo_r[15:0];
          end
          diff_nxt = (W + 1)'(samp_r) - (W + 1)'(last_r);
        end
        OP_MUL1: begin
          prod_nxt = mul_a * mul_b;
        end
        OP_EST: begin
          // floor of gain*diff/65536 is the arithmetic shift
          new_nxt = last_r + signed'(prod_r[16 +: W]);
        end
        OP_ABS_MUL2: begin
          dabs_nxt = dd[W] ? dneg[W-1:0] : dd[W-1:0];
          prod_nxt = mul_a * mul_b;
        end
        OP_MUL3: begin
          e1_nxt   = prod_r[31:16];
          prod_nxt = mul_a * mul_b;
        end
        OP_UPD: begin
          err_nxt    = err_sat;
          last_nxt   = new_r;
          oest_nxt   = new_r;
          oerr_nxt   = err_sat;
          ofirst_nxt = 1'b0;
          out_load   = 1'b1;
        end
        OP_FIRST: begin
          last_nxt   = samp_r;
          primed_nxt = 1'b1;
          oest_nxt   = samp_r;
          oerr_nxt   = err_r;
          ofirst_nxt = 1'b1;
          out_load   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      err_r    <= INIT_ERR_RST;
      primed_r <= 1'b0;
    end else begin
      last_r   <= last_nxt;
      err_r    <= err_nxt;
      primed_r <= primed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r     <= samp_nxt;
    rst_flag_r <= rst_flag_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    gain_r     <= gain_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    new_r      <= new_nxt;
    dabs_r     <= dabs_nxt;
    e1_r       <= e1_nxt;
    oest_r     <= oest_nxt;
    oerr_r     <= oerr_nxt;
    ofirst_r   <= ofirst_nxt;
  end

  assign stat = '{first: !(primed_r && !rst_flag_r), cnt_zero: (cnt_r == '0)};

  assign out_estimate       = oest_r;
  assign out_error_estimate = oerr_r;
  assign out_first_sample   = ofirst_r;

endmodule

[rtl/scalar_kalman_smoother_core.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_smoother_core: adaptive one-dimensional Kalman smoother
// Smooths signed Q8.8 level samples; a microcoded sequencer steps a small
// divide/multiply datapath through each update.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_ready   | in_sample, in_restart
//  out      | out_valid / out_ready | out_estimate, out_error_estimate,
//           |                       | out_first_sample
//  config   | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
//  A regular sample runs 25 steps: accept, load, 17 restoring-divide steps
//  for the gain, then six steps, three of which use the one multiplier. The
//  update step loads its result word and returns to the idle step. A first
//  sample (after reset or restart) skips the arithmetic: after the load step,
//  a first step loads the result and returns to the idle step.
//  One word is in flight at a time; in_ready is high only at the idle step.
//  The result register frees the core: a new word is accepted while the last
//  result waits; the core stalls on its final step only if that result is
//  still untaken. Reset is synchronous and active low; no clearing pass.
//
module scalar_kalman_smoother_core #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_estimate,
  output logic [15:0]                    out_error_estimate,
  output logic                           out_first_sample,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ksm_pkg::*;

  // configuration registers: R, q and the starting error
  logic [15:0] mnoise_r, mnoise_nxt;
  logic [15:0] pnoise_r, pnoise_nxt;
  logic [15:0] init_err_r, init_err_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        out_load;
  logic        out_free;
  pc_t         pc;
  uword_t      uword;
  ctrl_t       ctrl;
  stat_t       stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    mnoise_nxt   = mnoise_r;
    pnoise_nxt   = pnoise_r;
    init_err_nxt = init_err_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MNOISE:   mnoise_nxt   = pwdata[15:0];
        REG_PNOISE:   pnoise_nxt   = pwdata[15:0];
        REG_INIT_ERR: init_err_nxt = pwdata[15:0];
        default: begin
          // unmapped slot: drop the write
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MNOISE:   prdata = {16'h0000, mnoise_r};
      REG_PNOISE:   prdata = {16'h0000, pnoise_r};
      REG_INIT_ERR: prdata = {16'h0000, init_err_r};
      default:      prdata = '0;
    endcase
  end

  // result slot: fill on the final step, drain on out_ready
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mnoise_r    <= MNOISE_RST;
      pnoise_r    <= PNOISE_RST;
      init_err_r  <= INIT_ERR_RST;
      out_valid_r <= 1'b0;
    end else begin
      mnoise_r    <= mnoise_nxt;
      pnoise_r    <= pnoise_nxt;
      init_err_r  <= init_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // control store
  ksm_rom u_rom (
    .pc    (pc),
    .uword (uword)
  );

  // step counter and branches
  ksm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .uword    (uword),
    .stat     (stat),
    .in_valid (in_valid),
    .out_free (out_free),
    .pc       (pc),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  // arithmetic and filter state
  ksm_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .stat               (stat),
    .in_sample          (in_sample),
    .in_restart         (in_restart),
    .mnoise             (mnoise_r),
    .pnoise             (pnoise_r),
    .init_err           (init_err_r),
    .out_load           (out_load),
    .out_estimate       (out_estimate),
    .out_error_estimate (out_error_estimate),
    .out_first_sample   (out_first_sample)
  );

endmodule

[rtl/ksm_checker.sv]
// ----------------------------------------------------------------------------
// ksm_checker: port-level checks for the smoother core
// Watches the handshakes of the top level and flags sequencing slips.
// ----------------------------------------------------------------------------
module ksm_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_estimate,
  input logic [15:0]             out_error_estimate,
  input logic                    pready
);

  // one word at a time: the core leaves its idle step after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ksm: in_ready held after accept");

  // no result can appear in the cycle right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("ksm: result too early");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_estimate) &&
                                $stable(out_error_estimate))
    else $error("ksm: stalled result changed");

  // a stalled result is never dropped: out_valid stays high
  assert property (@(posedge clk) disable iff (!rst_n)
    pready && out_valid && !out_ready |=> out_valid)
    else $error("ksm: stalled result lost");

endmodule

bind scalar_kalman_smoother_core ksm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ksm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_estimate       (out_estimate),
  .out_error_estimate (out_error_estimate),
  .pready             (pready)
);
